@@ design/i6p_pkg.sv @@
package i6p_pkg;

  // An IPv6 address is eight 16-bit groups.
  localparam int unsigned GROUPS_N = 8;
  localparam int unsigned GROUP_W  = 16;
  localparam int unsigned GIDX_W   = $clog2(GROUPS_N);
  localparam int unsigned GCNT_W   = $clog2(GROUPS_N) + 1;
  localparam int unsigned ADDR_W   = GROUPS_N * GROUP_W;

  // Text bytes the parser reacts to.
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  // Limits of the dotted IPv4 tail.
  localparam logic [15:0] BCD_MAX        = 16'h0255;
  localparam logic [15:0] BCD_TENS_MASK  = 16'h00f0;
  localparam logic [15:0] BCD_TENS_MAX   = 16'h0090;
  localparam logic [3:0]  BCD_DIGIT_MAX  = 4'd9;
  localparam logic [11:0] OCTET_MAX      = 12'd255;
  localparam logic [GCNT_W-1:0] V4_GROUP_LIMIT = GCNT_W'(GROUPS_N - 2);

  typedef enum logic [6:0] {
    PH_START     = 7'b0000001,
    PH_LEAD      = 7'b0000010,
    PH_TOP       = 7'b0000100,
    PH_HEX       = 7'b0001000,
    PH_COLON     = 7'b0010000,
    PH_V4_FIRST  = 7'b0100000,
    PH_V4_DIGITS = 7'b1000000
  } phase_t;

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_STEP    = 4'b0010,
    ST_STRETCH = 4'b0100,
    ST_EMIT    = 4'b1000
  } seq_t;

  typedef enum logic [1:0] {
    ALU_NONE = 2'd0,
    ALU_HEX  = 2'd1,
    ALU_DEC  = 2'd2,
    ALU_BCD  = 2'd3
  } alu_op_t;

  typedef struct packed {
    logic                flag;
    logic [GROUP_W-1:0]  value;
  } alu_res_t;

  typedef struct packed {
    logic                we;
    logic [GIDX_W-1:0]   addr;
    logic [GROUP_W-1:0]  data;
  } grp_wr_t;

  // Returns {valid, nibble} for a hex digit character.
  function automatic logic [4:0] hex_digit(input logic [7:0] ch);
    logic [4:0] res;
    res = 5'd0;
    if (ch >= CH_ZERO && ch <= CH_NINE) begin
      res = {1'b1, ch[3:0]};
    end else if ((ch >= CH_LOW_A && ch <= CH_LOW_F) || (ch >= CH_UP_A && ch <= CH_UP_F)) begin
      res = {1'b1, 4'(ch[3:0] + 4'd9)};
    end
    return res;
  endfunction

endpackage

@@ design/i6p_alu.sv @@
module i6p_alu (
  input  i6p_pkg::alu_op_t  op,
  input  logic [15:0]       hex_in,
  input  logic [7:0]        octet_in,
  input  logic [3:0]        digit,
  output i6p_pkg::alu_res_t res
);
  import i6p_pkg::*;

  logic [11:0] dec_sum;
  logic [10:0] bcd_sum;
  logic        bcd_bad;

  // Decimal accumulate: octet * 10 + digit.
  assign dec_sum = ({4'd0, octet_in} << 3) + ({4'd0, octet_in} << 1) + {8'd0, digit};

  // BCD to binary for the first IPv4 number.
  assign bcd_sum = 11'(hex_in[11:8]) * 11'd100 + 11'(hex_in[7:4]) * 11'd10
                 + 11'(hex_in[3:0]);
  assign bcd_bad = (hex_in > BCD_MAX) || ((hex_in & BCD_TENS_MASK) > BCD_TENS_MAX)
                 || (hex_in[3:0] > BCD_DIGIT_MAX);

  always_comb begin
    res = '0;
    unique case (op)
      ALU_HEX: res = '{flag: 1'b0, value: {hex_in[11:0], digit}};
      ALU_DEC: res = '{flag: (dec_sum > OCTET_MAX), value: {4'd0, dec_sum}};
      ALU_BCD: res = '{flag: bcd_bad, value: {bcd_sum[7:0], 8'd0}};
      default: res = '0;
    endcase
  end

endmodule

@@ design/i6p_group_file.sv @@
module i6p_group_file (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       clr,
  input  i6p_pkg::grp_wr_t                           wr,
  input  logic [i6p_pkg::GIDX_W-1:0]                 rd_addr,
  output logic [i6p_pkg::GROUP_W-1:0]                rd_data,
  output logic [i6p_pkg::ADDR_W-1:0]                 flat
);
  import i6p_pkg::*;

  logic [GROUP_W-1:0] grp_r [GROUPS_N];

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      for (int i = 0; i < GROUPS_N; i++) begin
        grp_r[i] <= '0;
      end
    end else if (wr.we) begin
      grp_r[wr.addr] <= wr.data;
    end
  end

  assign rd_data = grp_r[rd_addr];

  // Group 0 lands in the top bits of the address.
  always_comb begin
    for (int i = 0; i < GROUPS_N; i++) begin
      flat[ADDR_W-1-GROUP_W*i -: GROUP_W] = grp_r[i];
    end
  end

endmodule

@@ design/ipv6_text_to_address_unit.sv @@
// A text byte is taken in the idle state and worked in the step state in the next
// cycle; no new byte is taken until idle comes back. A terminator goes from step,
// through the gap stretch if a valid string had a gap, to emit. The gap stretch
// moves one group per cycle through the group file.
// Reset (rst_n low, synchronous) clears the parser, the groups and the output valid.
module ipv6_text_to_address_unit (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,   // [7:0] ch
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [127:0]  out_tdata,  // [63:0] address_high, [127:64] address_low
  output logic [0:0]    out_tuser   // [0] ok
);
  import i6p_pkg::*;

  // The sequencer idles until a byte arrives, then works on it in the step
  // state. Hex, decimal and BCD arithmetic all go through the one
  // shared ALU. A terminator goes straight to emit, unless a valid string
  // had a gap; then the sequencer walks the group file from the top entry
  // down to move the groups behind the gap to the end of the address.
  seq_t                state_r, state_nxt;
  phase_t              phase_r, phase_nxt;
  logic [7:0]          ch_r, ch_nxt;
  logic [GCNT_W-1:0]   group_count_r, group_count_nxt;
  logic                gap_seen_r, gap_seen_nxt;
  logic [GCNT_W-1:0]   gap_index_r, gap_index_nxt;
  logic [15:0]         hex_value_r, hex_value_nxt;
  logic [2:0]          digit_count_r, digit_count_nxt;
  logic [7:0]          octet_r, octet_nxt;
  logic                failed_r, failed_nxt;
  logic [GIDX_W-1:0]   idx_r, idx_nxt;

  logic                out_ok_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic                out_tvalid_r;
  logic                out_load;

  logic [4:0]          hd;
  logic                is_colon;
  logic                is_dot;
  logic                is_dec;
  logic                gc_full;
  logic                fin_fail;
  logic [GCNT_W-1:0]   gc_fin;
  logic [GCNT_W:0]     stretch_span;
  logic                stretch_copy;

  alu_op_t             alu_op;
  alu_res_t            alu_res;
  grp_wr_t             gw;
  logic                grp_clr;
  logic [GIDX_W-1:0]   rd_addr;
  logic [GROUP_W-1:0]  rd_data;
  logic [ADDR_W-1:0]   grp_flat;

  assign hd       = hex_digit(ch_r);
  assign is_colon = (ch_r == CH_COLON);
  assign is_dot   = (ch_r == CH_DOT);
  assign is_dec   = (ch_r >= CH_ZERO) && (ch_r <= CH_NINE);
  assign gc_full  = (group_count_r >= GCNT_W'(GROUPS_N));

  // In the stretch, entry idx takes a copied group when idx lies in the last
  // (group_count - gap_index) places; its source is idx + group_count - 8.
  assign stretch_span = {2'b00, idx_r} + {1'b0, group_count_r} - {1'b0, gap_index_r};
  assign stretch_copy = (stretch_span >= (GCNT_W + 1)'(GROUPS_N));

  // Only the hex phase and the IPv4 digits phase need arithmetic on a normal byte.
  always_comb begin
    alu_op = ALU_NONE;
    if (state_r == ST_STEP && ch_r != CH_NUL && !failed_r) begin
      if (phase_r == PH_HEX) begin
        alu_op = (hd[4] && digit_count_r < 3'd4) ? ALU_HEX : ALU_BCD;
      end else if (phase_r == PH_V4_DIGITS) begin
        alu_op = ALU_DEC;
      end
    end
  end

  i6p_alu u_alu (
    .op       (alu_op),
    .hex_in   (hex_value_r),
    .octet_in (octet_r),
    .digit    (hd[3:0]),
    .res      (alu_res)
  );

  i6p_group_file u_groups (
    .clk     (clk),
    .rst_n   (rst_n),
    .clr     (grp_clr),
    .wr      (gw),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .flat    (grp_flat)
  );

  always_comb begin
    state_nxt       = state_r;
    phase_nxt       = phase_r;
    ch_nxt          = ch_r;
    group_count_nxt = group_count_r;
    gap_seen_nxt    = gap_seen_r;
    gap_index_nxt   = gap_index_r;
    hex_value_nxt   = hex_value_r;
    digit_count_nxt = digit_count_r;
    octet_nxt       = octet_r;
    failed_nxt      = failed_r;
    idx_nxt         = idx_r;
    gw              = '{we: 1'b0, addr: group_count_r[GIDX_W-1:0], data: '0};
    rd_addr         = group_count_r[GIDX_W-1:0];
    grp_clr         = 1'b0;
    out_load        = 1'b0;
    fin_fail        = 1'b0;
    gc_fin          = group_count_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          ch_nxt    = in_tdata;
          state_nxt = ST_STEP;
        end
      end

      ST_STEP: begin
        if (ch_r == CH_NUL) begin
          // End of string: close the open group, then check the group count.
          state_nxt = ST_EMIT;
          if (!failed_r) begin
            unique case (phase_r)
              PH_TOP: begin
              end
              PH_HEX: begin
                if (gc_full) begin
                  fin_fail = 1'b1;
                end else begin
                  gw     = '{we: 1'b1, addr: group_count_r[GIDX_W-1:0], data: hex_value_r};
                  gc_fin = group_count_r + 1'b1;
                end
              end
              PH_V4_DIGITS: begin
                if (digit_count_r != 3'd3 || gc_full) begin
                  fin_fail = 1'b1;
                end else begin
                  gw     = '{we: 1'b1, addr: group_count_r[GIDX_W-1:0],
                             data: {rd_data[15:8], octet_r}};
                  gc_fin = group_count_r + 1'b1;
                end
              end
              default: fin_fail = 1'b1;
            endcase
            if (!fin_fail) begin
              if (gap_seen_r) begin
                if (gap_index_r > gc_fin) begin
                  fin_fail = 1'b1;
                end else begin
                  state_nxt = ST_STRETCH;
                  idx_nxt   = GIDX_W'(GROUPS_N - 1);
                end
              end else if (gc_fin != GCNT_W'(GROUPS_N)) begin
                fin_fail = 1'b1;
              end
            end
            if (fin_fail) begin
              gw.we = 1'b0;
            end
            failed_nxt      = fin_fail;
            group_count_nxt = gc_fin;
          end
        end else begin
          state_nxt = ST_IDLE;
          if (!failed_r) begin
            unique case (phase_r)
              PH_START, PH_TOP, PH_COLON: begin
                if (phase_r == PH_START && is_colon) begin
                  phase_nxt = PH_LEAD;
                end else if (gc_full) begin
                  failed_nxt = 1'b1;
                end else if (is_colon) begin
                  // A gap: its own zero group counts as one group.
                  if (gap_seen_r) begin
                    failed_nxt = 1'b1;
                  end else begin
                    gw              = '{we: 1'b1, addr: group_count_r[GIDX_W-1:0], data: '0};
                    group_count_nxt = group_count_r + 1'b1;
                    gap_seen_nxt    = 1'b1;
                    gap_index_nxt   = group_count_r + 1'b1;
                    phase_nxt       = PH_TOP;
                  end
                end else if (!hd[4]) begin
                  failed_nxt = 1'b1;
                end else begin
                  hex_value_nxt   = {12'd0, hd[3:0]};
                  digit_count_nxt = 3'd1;
                  phase_nxt       = PH_HEX;
                end
              end
              PH_LEAD: begin
                if (is_colon) begin
                  gw              = '{we: 1'b1, addr: '0, data: '0};
                  group_count_nxt = GCNT_W'(1);
                  gap_seen_nxt    = 1'b1;
                  gap_index_nxt   = GCNT_W'(1);
                  phase_nxt       = PH_TOP;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
              PH_HEX: begin
                if (hd[4] && digit_count_r < 3'd4) begin
                  hex_value_nxt   = alu_res.value;
                  digit_count_nxt = digit_count_r + 1'b1;
                end else if (is_dot) begin
                  // The hex group read so far is the first IPv4 number, in BCD.
                  if (group_count_r > V4_GROUP_LIMIT || alu_res.flag) begin
                    failed_nxt = 1'b1;
                  end else begin
                    gw              = '{we: 1'b1, addr: group_count_r[GIDX_W-1:0],
                                        data: alu_res.value};
                    digit_count_nxt = 3'd1;
                    phase_nxt       = PH_V4_FIRST;
                  end
                end else if (is_colon) begin
                  if (gc_full) begin
                    failed_nxt = 1'b1;
                  end else begin
                    gw              = '{we: 1'b1, addr: group_count_r[GIDX_W-1:0],
                                        data: hex_value_r};
                    group_count_nxt = group_count_r + 1'b1;
                    phase_nxt       = PH_COLON;
                  end
                end else begin
                  failed_nxt = 1'b1;
                end
              end
              PH_V4_FIRST: begin
                if (is_dec) begin
                  octet_nxt = {4'd0, hd[3:0]};
                  phase_nxt = PH_V4_DIGITS;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
              PH_V4_DIGITS: begin
                if (is_dec) begin
                  if (alu_res.flag) begin
                    failed_nxt = 1'b1;
                  end else begin
                    octet_nxt = alu_res.value[7:0];
                  end
                end else if (is_dot && digit_count_r < 3'd3) begin
                  // Even-numbered octets go to the high byte, odd ones close the group.
                  if (gc_full) begin
                    failed_nxt = 1'b1;
                  end else if (digit_count_r == 3'd2) begin
                    gw = '{we: 1'b1, addr: group_count_r[GIDX_W-1:0], data: {octet_r, 8'd0}};
                  end else begin
                    gw              = '{we: 1'b1, addr: group_count_r[GIDX_W-1:0],
                                        data: {rd_data[15:8], octet_r}};
                    group_count_nxt = group_count_r + 1'b1;
                  end
                  digit_count_nxt = digit_count_r + 1'b1;
                  phase_nxt       = PH_V4_FIRST;
                end else begin
                  failed_nxt = 1'b1;
                end
              end
              default: failed_nxt = 1'b1;
            endcase
          end
        end
      end

      ST_STRETCH: begin
        // Walking downward keeps every source entry intact until it is read.
        rd_addr = GIDX_W'(idx_r + group_count_r[GIDX_W-1:0]);
        if ({1'b0, idx_r} >= gap_index_r) begin
          gw = '{we: 1'b1, addr: idx_r, data: stretch_copy ? rd_data : '0};
        end
        if (idx_r == '0) begin
          state_nxt = ST_EMIT;
        end else begin
          idx_nxt = idx_r - 1'b1;
        end
      end

      ST_EMIT: begin
        if (!out_tvalid_r || out_tready) begin
          out_load        = 1'b1;
          grp_clr         = 1'b1;
          state_nxt       = ST_IDLE;
          phase_nxt       = PH_START;
          group_count_nxt = '0;
          gap_seen_nxt    = 1'b0;
          gap_index_nxt   = '0;
          hex_value_nxt   = '0;
          digit_count_nxt = '0;
          octet_nxt       = '0;
          failed_nxt      = 1'b0;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_r       <= PH_START;
      ch_r          <= '0;
      group_count_r <= '0;
      gap_seen_r    <= 1'b0;
      gap_index_r   <= '0;
      hex_value_r   <= '0;
      digit_count_r <= '0;
      octet_r       <= '0;
      failed_r      <= 1'b0;
      idx_r         <= '0;
    end else begin
      state_r       <= state_nxt;
      phase_r       <= phase_nxt;
      ch_r          <= ch_nxt;
      group_count_r <= group_count_nxt;
      gap_seen_r    <= gap_seen_nxt;
      gap_index_r   <= gap_index_nxt;
      hex_value_r   <= hex_value_nxt;
      digit_count_r <= digit_count_nxt;
      octet_r       <= octet_nxt;
      failed_r      <= failed_nxt;
      idx_r         <= idx_nxt;
    end
  end

  // Output register: a finished item waits here while the parser takes new bytes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (out_load) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ok_r   <= !failed_r;
      out_addr_r <= failed_r ? '0 : grp_flat;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = {out_addr_r[ADDR_W/2-1:0], out_addr_r[ADDR_W-1:ADDR_W/2]};

  a_gc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    group_count_r <= GCNT_W'(GROUPS_N))
    else $error("group count above eight");

  a_gap_index: assert property (@(posedge clk) disable iff (!rst_n)
    gap_seen_r |-> (gap_index_r != '0) && (gap_index_r <= group_count_r))
    else $error("gap index outside the counted groups");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata == '0)
    else $error("rejected string with nonzero address");

  a_stretch_start: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_STEP && state_nxt == ST_STRETCH |=> idx_r == GIDX_W'(GROUPS_N - 1))
    else $error("stretch walk does not start at the top group");

  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> group_count_r == '0 && !failed_r && !gap_seen_r && out_tvalid)
    else $error("parser not restarted after a result");

endmodule
